// File: rtl/bscf_pkg.sv
// Types and constants shared by the bit stuffing CRC framer and its checker.
package bscf_pkg;

  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 2;
  localparam int FlagW    = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_FLAG   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_POLY   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DEGREE = 2'd2;

  // Line bit kinds
  localparam logic [1:0] KIND_FLAG  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_STUFF = 2'd2;
  localparam logic [1:0] KIND_CRC   = 2'd3;

  typedef struct packed {
    logic data_bit;
    logic frame_last;
  } in_t;

  typedef struct packed {
    logic       line_bit;
    logic [1:0] bit_kind;
    logic       run_last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPEN,
    ST_DATA,
    ST_STUFF,
    ST_CRC,
    ST_CLOSE
  } seq_state_t;

endpackage

// File: rtl/bit_stuff_crc_framer_top.sv
// Serial framer: opening flag, bit-stuffed data, CRC remainder, closing flag.
//
//   port group   dir   handshake             payload
//   in_          in    in_valid / in_ready   in_data (in_t)
//   out_         out   out_valid / out_ready out_data (out_t)
//   cfg_         in    cfg_we                cfg_index, cfg_wdata
//
// One line bit leaves per cycle while the output is not stalled; an item causes
// 1 line bit for a plain data bit, +1 for a stuffed zero, +8 for an opening
// flag, +degree+8 for the frame end. The single output serializer sets this.
// Frame state and CRC update when the request is accepted, so a data-only item
// can be accepted every cycle. Reset is synchronous; no clearing pass.
// in_ready drops while a sequence is still being emitted or the output stalls.
module bit_stuff_crc_framer_top
  import bscf_pkg::*;
#(
  parameter int MAX_CRC_DEGREE = 16,
  parameter int STUFF_RUN      = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_t                out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  localparam int MaxD = MAX_CRC_DEGREE;
  localparam int DW   = $clog2(MaxD + 1);
  localparam int CW   = ($clog2(MaxD) > 3) ? $clog2(MaxD) : 3;
  localparam logic [5:0] MaxD6     = 6'(MaxD);
  localparam logic [CW-1:0] FlagTop = CW'(FlagW - 1);
  localparam logic [3:0] StuffRun4  = 4'(STUFF_RUN);

  // configuration
  logic [FlagW-1:0]    flag_r;
  logic [CfgDataW-1:0] poly_r;
  logic [4:0]          degree_r;

  // frame state
  logic                in_frame_r;
  logic [2:0]          ones_r;
  logic [MaxD-1:0]     crc_r;

  // item being emitted
  logic                it_bit_r;
  logic                it_last_r;
  logic                it_stuff_r;
  logic [MaxD-1:0]     it_crc_r;

  seq_state_t          st_r, st_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;

  logic                out_valid_r;
  out_t                out_data_r;

  logic [5:0]          deg6;
  logic [DW-1:0]       eff_deg;
  logic [MaxD-1:0]     deg_mask;
  logic [MaxD-1:0]     top_sel;
  logic [MaxD-1:0]     poly_m;
  logic [31:0]         poly32;

  logic                acc;
  logic                advance;
  logic                slot_bit;
  logic [1:0]          slot_kind;
  logic                slot_final;
  logic                crc_sel_bit;

  logic [MaxD-1:0]     crc0, crc1, crc2;
  logic [2:0]          ones0;
  logic [3:0]          ones1;
  logic                stuff;

  function automatic logic [MaxD-1:0] crc_step(
    input logic [MaxD-1:0] r_in,
    input logic            b,
    input logic [MaxD-1:0] mask,
    input logic [MaxD-1:0] sel,
    input logic [MaxD-1:0] pm
  );
    logic [MaxD-1:0] r;
    logic            fb;
    r  = r_in & mask;
    fb = (|(r & sel)) ^ b;
    r  = (r << 1) & mask;
    if (fb) r = r ^ pm;
    return r;
  endfunction

  // effective degree, clamped to 1..MAX_CRC_DEGREE
  always_comb begin
    deg6 = {1'b0, degree_r};
    if (deg6 == 6'd0) deg6 = 6'd1;
    else if (deg6 > MaxD6) deg6 = MaxD6;
    eff_deg = deg6[DW-1:0];
  end

  assign poly32 = {16'b0, poly_r};
  assign poly_m = poly32[MaxD-1:0] & deg_mask;

  always_comb begin
    for (int i = 0; i < MaxD; i++) begin
      deg_mask[i] = (DW'(i) < eff_deg);
      top_sel[i]  = (DW'(i) == eff_deg - DW'(1));
    end
  end

  // one pass of the frame state for the incoming request
  always_comb begin
    crc0  = in_frame_r ? crc_r : '0;
    ones0 = in_frame_r ? ones_r : 3'd0;
    crc1  = crc_step(crc0, in_data.data_bit, deg_mask, top_sel, poly_m);
    ones1 = in_data.data_bit ? ({1'b0, ones0} + 4'd1) : 4'd0;
    stuff = (ones1 >= StuffRun4);
    crc2  = stuff ? crc_step(crc1, 1'b0, deg_mask, top_sel, poly_m) : crc1;
  end

  assign advance  = (st_r != ST_IDLE) && (!out_valid_r || out_ready);
  assign in_ready = (st_r == ST_IDLE) || (advance && slot_final);
  assign acc      = in_valid && in_ready;

  always_comb begin
    crc_sel_bit = 1'b0;
    for (int i = 0; i < MaxD; i++) begin
      if (cnt_r == CW'(i)) crc_sel_bit = it_crc_r[i];
    end
  end

  // current slot
  always_comb begin
    slot_bit   = 1'b0;
    slot_kind  = KIND_FLAG;
    slot_final = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        slot_bit = 1'b0;
      end
      ST_OPEN: begin
        slot_bit  = flag_r[cnt_r[2:0]];
        slot_kind = KIND_FLAG;
      end
      ST_DATA: begin
        slot_bit   = it_bit_r;
        slot_kind  = KIND_DATA;
        slot_final = !it_stuff_r && !it_last_r;
      end
      ST_STUFF: begin
        slot_bit   = 1'b0;
        slot_kind  = KIND_STUFF;
        slot_final = !it_last_r;
      end
      ST_CRC: begin
        slot_bit  = crc_sel_bit;
        slot_kind = KIND_CRC;
      end
      ST_CLOSE: begin
        slot_bit   = flag_r[cnt_r[2:0]];
        slot_kind  = KIND_FLAG;
        slot_final = (cnt_r == '0);
      end
      default: begin
        slot_bit = 1'b0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    priority if (acc) begin
      if (in_frame_r) begin
        st_nxt = ST_DATA;
      end else begin
        st_nxt  = ST_OPEN;
        cnt_nxt = FlagTop;
      end
    end else if (advance) begin
      unique case (st_r)
        ST_IDLE: begin
          st_nxt = ST_IDLE;
        end
        ST_OPEN: begin
          if (cnt_r == '0) st_nxt = ST_DATA;
          else cnt_nxt = cnt_r - CW'(1);
        end
        ST_DATA: begin
          if (it_stuff_r) begin
            st_nxt = ST_STUFF;
          end else if (it_last_r) begin
            st_nxt  = ST_CRC;
            cnt_nxt = CW'(eff_deg - DW'(1));
          end else begin
            st_nxt = ST_IDLE;
          end
        end
        ST_STUFF: begin
          if (it_last_r) begin
            st_nxt  = ST_CRC;
            cnt_nxt = CW'(eff_deg - DW'(1));
          end else begin
            st_nxt = ST_IDLE;
          end
        end
        ST_CRC: begin
          if (cnt_r == '0) begin
            st_nxt  = ST_CLOSE;
            cnt_nxt = FlagTop;
          end else begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        ST_CLOSE: begin
          if (cnt_r == '0) st_nxt = ST_IDLE;
          else cnt_nxt = cnt_r - CW'(1);
        end
        default: begin
          st_nxt = ST_IDLE;
        end
      endcase
    end else begin
      st_nxt  = st_r;
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= 8'h7E;
      poly_r      <= 16'd3;
      degree_r    <= 5'd3;
      in_frame_r  <= 1'b0;
      ones_r      <= 3'd0;
      crc_r       <= '0;
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FLAG:   flag_r   <= cfg_wdata[FlagW-1:0];
          REG_POLY:   poly_r   <= cfg_wdata;
          REG_DEGREE: degree_r <= cfg_wdata[4:0];
          default:    ;
        endcase
      end
      if (acc) begin
        if (in_data.frame_last) begin
          in_frame_r <= 1'b0;
          ones_r     <= 3'd0;
          crc_r      <= '0;
        end else begin
          in_frame_r <= 1'b1;
          ones_r     <= stuff ? 3'd0 : ones1[2:0];
          crc_r      <= crc2;
        end
      end
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      it_bit_r   <= in_data.data_bit;
      it_last_r  <= in_data.frame_last;
      it_stuff_r <= stuff;
      it_crc_r   <= crc2 & deg_mask;
    end
    if (advance) begin
      out_data_r.line_bit <= slot_bit;
      out_data_r.bit_kind <= slot_kind;
      out_data_r.run_last <= slot_final;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/bscf_checker.sv
// Port-level checker for the framer, bound to the top level.
module bscf_checker
  import bscf_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stuffed slot always carries a zero
  a_stuff_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bit_kind == KIND_STUFF |-> !out_data.line_bit)
    else $error("stuffed bit is not zero");

  // closing flag always follows the CRC, so a CRC bit never ends a request
  a_crc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bit_kind == KIND_CRC |-> !out_data.run_last)
    else $error("CRC bit marked as last");

  // handshake lines are always driven to known levels out of reset
  a_hs_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_valid, in_ready, out_valid, out_ready}))
    else $error("handshake line unknown");

endmodule

bind bit_stuff_crc_framer_top bscf_checker u_bscf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: test/bit_stuff_crc_framer_top_test.sv
// Self-checking testbench for the bit stuffing CRC framer: random requests, random stalls.
`timescale 1ns / 1ps

module bit_stuff_crc_framer_top_test;
  import bscf_pkg::*;

  localparam int MaxDegree = 16;
  localparam int StuffRun  = 5;
  localparam int RunLimit  = 500000;
  localparam int MaxPrints = 30;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  bit_stuff_crc_framer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Framer model state and register copies
  logic [7:0]  flag_reg = 8'h7E;
  logic [15:0] poly_reg = 16'h0003;
  logic [4:0]  degree_reg = 5'd3;
  logic        frame_open = 1'b0;
  logic [2:0]  ones_run = '0;
  logic [15:0] crc_rem = '0;

  in_t  msg_bits_q[$];
  out_t framed_bits_q[$];

  int unsigned pushed_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned pending_results = 0;
  int unsigned bits_seen = 0;
  int unsigned err_count = 0;
  int unsigned cycle_cnt = 0;

  int unsigned in_gap_max = 6;
  int unsigned out_gap_max = 6;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  int unsigned stall_draw;
  logic        sender_hold = 1'b0;

  task automatic report_error(string msg);
    err_count++;
    if (err_count <= MaxPrints) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int unsigned crc_width();
    int unsigned d;
    d = degree_reg;
    if (d < 1) d = 1;
    if (d > MaxDegree) d = MaxDegree;
    return d;
  endfunction

  task automatic crc_step(logic b);
    int unsigned d;
    logic [16:0] mask;
    logic [16:0] r;
    logic        fb;
    d = crc_width();
    mask = (17'd1 << d) - 17'd1;
    r = {1'b0, crc_rem} & mask;
    fb = r[d-1] ^ b;
    r = (r << 1) & mask;
    if (fb) r = r ^ ({1'b0, poly_reg} & mask);
    crc_rem = r[15:0];
  endtask

  task automatic emit_bit(logic b, logic [1:0] kind);
    out_t t;
    t.line_bit = b;
    t.bit_kind = kind;
    t.run_last = 1'b0;
    framed_bits_q.push_back(t);
  endtask

  task automatic emit_flag();
    int i;
    for (i = 7; i >= 0; i--) emit_bit(flag_reg[i], KIND_FLAG);
  endtask

  // Line bits caused by one message bit
  task automatic frame_message_bit(in_t item);
    int unsigned k;
    out_t tail;
    if (!frame_open) begin
      emit_flag();
      frame_open = 1'b1;
      ones_run = '0;
      crc_rem = '0;
    end
    emit_bit(item.data_bit, KIND_DATA);
    crc_step(item.data_bit);
    if (item.data_bit) ones_run = ones_run + 3'd1;
    else ones_run = '0;
    if (ones_run >= StuffRun) begin
      emit_bit(1'b0, KIND_STUFF);
      crc_step(1'b0);
      ones_run = '0;
    end
    if (item.frame_last) begin
      for (k = crc_width(); k > 0; k--) emit_bit(crc_rem[k-1], KIND_CRC);
      emit_flag();
      frame_open = 1'b0;
      ones_run = '0;
      crc_rem = '0;
    end
    tail = framed_bits_q.pop_back();
    tail.run_last = 1'b1;
    framed_bits_q.push_back(tail);
  endtask

  // Sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_wait != 0) begin
        in_valid <= 1'b0;
        in_wait <= in_wait - 1;
      end else if (msg_bits_q.size() != 0 && !sender_hold) begin
        in_valid <= 1'b1;
        in_data <= msg_bits_q.pop_front();
        in_wait <= $urandom_range(0, in_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall drawn before each result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait <= 0;
    end else if (out_wait != 0) begin
      out_wait <= out_wait - 1;
    end else if (out_ready && out_valid) begin
      stall_draw = $urandom_range(0, out_gap_max);
      if (stall_draw != 0) begin
        out_ready <= 1'b0;
        out_wait <= stall_draw - 1;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Predict on request accept, then check any result taken at the same edge
  always @(posedge clk) begin : check_line
    out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        frame_message_bit(in_data);
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        if (framed_bits_q.size() == 0) begin
          report_error($sformatf("line bit %0d arrived with nothing pending", bits_seen));
        end else begin
          want = framed_bits_q.pop_front();
          if (out_data.line_bit !== want.line_bit)
            report_error($sformatf("line bit %0d: line_bit %b, want %b",
                                   bits_seen, out_data.line_bit, want.line_bit));
          if (out_data.bit_kind !== want.bit_kind)
            report_error($sformatf("line bit %0d: bit_kind %0d, want %0d",
                                   bits_seen, out_data.bit_kind, want.bit_kind));
          if (out_data.run_last !== want.run_last)
            report_error($sformatf("line bit %0d: run_last %b, want %b",
                                   bits_seen, out_data.run_last, want.run_last));
        end
        bits_seen++;
      end
      pending_results = framed_bits_q.size();
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RunLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_msg(logic b, logic last);
    in_t item;
    item.data_bit = b;
    item.frame_last = last;
    msg_bits_q.push_back(item);
    pushed_cnt++;
  endtask

  task automatic push_frame(int unsigned len, int unsigned ones_pct);
    int unsigned i;
    for (i = 1; i <= len; i++) push_msg($urandom_range(0, 99) < ones_pct, i == len);
  endtask

  task automatic drain();
    wait (accepted_cnt == pushed_cnt && pending_results == 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FLAG:   flag_reg = val[7:0];
      REG_POLY:   poly_reg = val;
      REG_DEGREE: degree_reg = val[4:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned phase, goal, mark, deg;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one-bit frame, then a run of five ones that gets stuffed
    push_msg(1'b1, 1'b1);
    push_msg(1'b1, 1'b0);
    push_msg(1'b1, 1'b0);
    push_msg(1'b1, 1'b0);
    push_msg(1'b1, 1'b0);
    push_msg(1'b1, 1'b0);
    push_msg(1'b0, 1'b1);
    drain();

    // Widest CRC, all-ones flag and generator: longest item
    write_reg(REG_FLAG, 16'hFFFF);
    write_reg(REG_POLY, 16'hFFFF);
    write_reg(REG_DEGREE, 16'd16);
    end_writes();
    push_msg(1'b1, 1'b1);
    push_msg(1'b0, 1'b1);
    drain();

    // Degree zero runs as one; the spare index is ignored
    write_reg(REG_FLAG, 16'h0000);
    write_reg(REG_POLY, 16'h0000);
    write_reg(REG_DEGREE, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    end_writes();
    push_msg(1'b1, 1'b0);
    push_msg(1'b0, 1'b1);
    drain();

    // Degree above the maximum clamps; then a change of degree mid-frame
    write_reg(REG_DEGREE, 16'd31);
    write_reg(REG_POLY, 16'hA5C3);
    end_writes();
    push_msg(1'b1, 1'b0);
    push_msg(1'b1, 1'b0);
    push_msg(1'b1, 1'b0);
    drain();
    write_reg(REG_DEGREE, 16'hFFE5);
    write_reg(REG_POLY, 16'hFFE5);
    end_writes();
    push_msg(1'b1, 1'b0);
    push_msg(1'b1, 1'b0);
    push_msg(1'b0, 1'b1);
    drain();

    for (phase = 0; phase < 6; phase++) begin
      write_reg(REG_FLAG, 16'($urandom_range(0, 65535)));
      write_reg(REG_POLY, 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: deg = 0;
          1: deg = 1;
          2: deg = 16;
          default: deg = 31;
        endcase
      end else begin
        deg = $urandom_range(1, 16);
      end
      write_reg(REG_DEGREE, {11'($urandom_range(0, 2047)), deg[4:0]});
      end_writes();

      // Some phases run without any idling on either side
      if (phase % 3 == 1) begin
        in_gap_max = 0;
        out_gap_max = 0;
      end else begin
        in_gap_max = 6;
        out_gap_max = 6;
      end

      goal = pushed_cnt + 22;
      mark = accepted_cnt + 10;
      while (pushed_cnt < goal) begin
        case ($urandom_range(0, 7))
          0:       push_frame($urandom_range(13, 40), 85);
          1, 2:    push_frame($urandom_range(1, 12), 50);
          default: push_frame($urandom_range(1, 12), 75);
        endcase
      end

      // Sender holds off mid-phase until the framer has emptied out
      if (phase == 2) begin
        wait (accepted_cnt >= mark);
        @(negedge clk);
        sender_hold = 1'b1;
        wait (!in_valid && pending_results == 0);
        @(negedge clk);
        sender_hold = 1'b0;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/bscf_pkg.sv
rtl/bit_stuff_crc_framer_top.sv
rtl/bscf_checker.sv
test/bit_stuff_crc_framer_top_test.sv
